/* rtl/scd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types and constants for the stream chunk deframer.
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int unsigned PREAMBLE_BYTES = 8;
  localparam int unsigned MAX_RESULTS    = 10;
  localparam int unsigned OQ_DEPTH       = 16;

  localparam logic [2:0] ST_DATA     = 3'd0;
  localparam logic [2:0] ST_BOUNDARY = 3'd1;
  localparam logic [2:0] ST_OFFSET   = 3'd2;
  localparam logic [2:0] ST_SRV_MSG  = 3'd3;
  localparam logic [2:0] ST_SRV_ERR  = 3'd4;
  localparam logic [2:0] ST_SHORT    = 3'd5;

  localparam logic [7:0] BOUNDARY_CH = 8'h5a;
  localparam logic [7:0] SKIP_CH     = 8'h62;
  localparam logic [7:0] MSG_CH      = 8'h58;
  localparam logic [7:0] ERR_CH      = 8'h46;
  localparam logic [7:0] FIRST_MASK  = 8'hfe;
  localparam logic [7:0] PERIOD_RST  = 8'd43;

  localparam logic [2:0] REG_PERIOD  = 3'd0;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       stream;
    logic [2:0] status;
    logic       ka;
  } res_t;

endpackage

/* rtl/scd_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_core
// Per-byte deframing step: window, body tracking, stream choice and result
// generation (up to ten results per request).
// ----------------------------------------------------------------------------
module scd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          in_byte,
  input  logic [7:0]          period,
  output logic [3:0]          res_n,
  output scd_pkg::res_t       res [scd_pkg::MAX_RESULTS]
);

  typedef enum logic [1:0] {PH_PRE, PH_SKIP, PH_SLIDE, PH_BODY} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  window_r [8];
  logic [7:0]  window_nxt [8];
  logic [3:0]  fill_r, fill_nxt;
  logic        skipped_r, skipped_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [15:0] flen_r, flen_nxt;
  logic [15:0] bpos_r, bpos_nxt;
  logic [7:0]  held_r [5];
  logic [7:0]  held_nxt [5];
  logic [15:0] eseq_r [4];
  logic [15:0] eseq_nxt [4];
  logic [31:0] lts_r [2];
  logic [31:0] lts_nxt [2];
  logic [7:0]  pphase_r, pphase_nxt;

  logic [8:0]  eff;
  logic        ka_now;

  assign eff    = (period == 8'd0) ? 9'd256 : {1'b0, period};
  assign ka_now = ({1'b0, pphase_r} == (eff - 9'd1));

  always_comb begin
    logic        do_check, do_report, do_end, do_burst, st, fin;
    logic [2:0]  rep_st;
    logic [15:0] size, f1, f2, s0, s1;
    logic [31:0] ts;
    logic [7:0]  bv;
    logic [2:0]  hidx;

    phase_nxt   = phase_r;
    window_nxt  = window_r;
    fill_nxt    = fill_r;
    skipped_nxt = skipped_r;
    skip_nxt    = skip_r;
    flen_nxt    = flen_r;
    bpos_nxt    = bpos_r;
    held_nxt    = held_r;
    eseq_nxt    = eseq_r;
    lts_nxt     = lts_r;
    pphase_nxt  = pphase_r;
    res_n       = 4'd0;
    for (int i = 0; i < scd_pkg::MAX_RESULTS; i++) res[i] = '0;
    do_check  = 1'b0;
    do_report = 1'b0;
    do_end    = 1'b0;
    do_burst  = 1'b0;
    rep_st    = scd_pkg::ST_DATA;
    st        = 1'b0;
    fin       = 1'b0;
    size      = {window_r[1], window_r[2]};
    f1        = '0;
    f2        = '0;
    s0        = '0;
    s1        = '0;
    ts        = '0;
    bv        = in_byte;
    hidx      = 3'd0;

    if (step) begin
      unique case (phase_r)
        PH_PRE: begin
          window_nxt[fill_r[2:0]] = in_byte;
          fill_nxt = fill_r + 4'd1;
          if (fill_r == 4'(scd_pkg::PREAMBLE_BYTES - 1)) begin
            fill_nxt    = 4'd0;
            skipped_nxt = 1'b1;
            if (!(!skipped_r && window_nxt[0] == scd_pkg::SKIP_CH)) begin
              size = {window_nxt[1], window_nxt[2]};
              if (window_nxt[0] == scd_pkg::MSG_CH) begin
                if (size <= 16'd5) begin
                  do_report = 1'b1;
                  rep_st    = scd_pkg::ST_SRV_MSG;
                end else begin
                  skip_nxt  = size - 16'd5;
                  phase_nxt = PH_SKIP;
                end
              end else if (window_nxt[0] == scd_pkg::ERR_CH) begin
                do_report = 1'b1;
                rep_st    = scd_pkg::ST_SRV_ERR;
              end else if (window_nxt[0] == scd_pkg::BOUNDARY_CH) begin
                do_check = 1'b1;
              end else begin
                phase_nxt = PH_SLIDE;
              end
            end
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_r - 16'd1;
          if (skip_nxt == 16'd0) begin
            do_report = 1'b1;
            rep_st    = scd_pkg::ST_SRV_MSG;
          end
        end
        PH_SLIDE: begin
          for (int i = 0; i < 7; i++) window_nxt[i] = window_r[i+1];
          window_nxt[7] = in_byte;
          if (window_nxt[0] == scd_pkg::BOUNDARY_CH) do_check = 1'b1;
        end
        PH_BODY: begin
          if (bpos_r < 16'd10) begin
            hidx = 3'(bpos_r - 16'd5);
            held_nxt[hidx] = in_byte;
            bpos_nxt = bpos_r + 16'd1;
            if (bpos_nxt == 16'd10) do_burst = 1'b1;
          end else begin
            bv  = (bpos_r == 16'd10) ? (in_byte & scd_pkg::FIRST_MASK) : in_byte;
            fin = ({1'b0, bpos_r} + 17'd1) >= {1'b0, flen_r};
            res[0] = '{data: bv, last: fin, stream: held_r[0][0],
                       status: scd_pkg::ST_DATA, ka: 1'b0};
            res_n    = 4'd1;
            bpos_nxt = bpos_r + 16'd1;
            if (fin) do_end = 1'b1;
          end
        end
        default: ;
      endcase

      if (do_check) begin
        f1 = {window_nxt[1], window_nxt[2]};
        f2 = {window_nxt[3], window_nxt[4]};
        if (window_nxt[7] != scd_pkg::BOUNDARY_CH) begin
          do_report = 1'b1;
          rep_st    = scd_pkg::ST_BOUNDARY;
        end else if (f1 != f2) begin
          do_report = 1'b1;
          rep_st    = scd_pkg::ST_OFFSET;
        end else if (f1 < 16'd10) begin
          do_report = 1'b1;
          rep_st    = scd_pkg::ST_SHORT;
        end else begin
          flen_nxt  = f1;
          bpos_nxt  = 16'd5;
          phase_nxt = PH_BODY;
        end
      end

      if (do_report) begin
        res[0] = '{data: 8'd0, last: 1'b1, stream: 1'b0, status: rep_st, ka: ka_now};
        res_n  = 4'd1;
        do_end = 1'b1;
      end

      if (do_burst) begin
        s0 = {window_r[5], window_r[6]};
        s1 = {8'd0, held_nxt[0]};
        ts = {held_nxt[1], held_nxt[2], held_nxt[3], held_nxt[4]};
        if ((s0 == eseq_r[0]) != (s0 == eseq_r[2])) begin
          if (s0 == eseq_r[0]) begin
            eseq_nxt[0] = eseq_r[0] + 16'd1;
            eseq_nxt[1] = s1 + 16'd1;
            st = 1'b0;
          end else begin
            eseq_nxt[2] = eseq_r[2] + 16'd1;
            eseq_nxt[3] = s1 + 16'd1;
            st = 1'b1;
          end
        end else if (s1 == eseq_r[1] && s1 != eseq_r[3]) begin
          eseq_nxt[0] = s0 + 16'd1;
          eseq_nxt[1] = eseq_r[1] + 16'd1;
          st = 1'b0;
        end else if (s1 == eseq_r[3] && s1 != eseq_r[1]) begin
          eseq_nxt[2] = s0 + 16'd1;
          eseq_nxt[3] = eseq_r[3] + 16'd1;
          st = 1'b1;
        end else if (ts < lts_r[1]) begin
          st = 1'b0;
        end else if (ts < lts_r[0]) begin
          st = 1'b1;
        end else begin
          eseq_nxt[0] = s0 + 16'd1;
          eseq_nxt[1] = s1 + 16'd1;
          st = 1'b0;
        end
        fin = (flen_r == 16'd10);
        lts_nxt[st] = ts;
        for (int k = 0; k < scd_pkg::MAX_RESULTS; k++) begin
          res[k] = '{data: 8'd0, last: 1'b0, stream: st,
                     status: scd_pkg::ST_DATA, ka: 1'b0};
        end
        res[0].ka   = ka_now;
        res[2].data = flen_r[15:8];
        res[3].data = flen_r[7:0];
        res[5].data = {7'd0, st};
        res[6].data = held_nxt[1];
        res[7].data = held_nxt[2];
        res[8].data = held_nxt[3];
        res[9].data = held_nxt[4];
        res[9].last = fin;
        res_n       = 4'd10;
        held_nxt[0] = {7'd0, st};
        if (({1'b0, pphase_r} + 9'd1) >= eff) pphase_nxt = 8'd0;
        else pphase_nxt = pphase_r + 8'd1;
        if (fin) do_end = 1'b1;
      end

      if (do_end) begin
        phase_nxt   = PH_PRE;
        fill_nxt    = 4'd0;
        skipped_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_PRE;
      fill_r    <= '0;
      skipped_r <= 1'b0;
      skip_r    <= '0;
      flen_r    <= '0;
      bpos_r    <= '0;
      pphase_r  <= '0;
      for (int i = 0; i < 8; i++) window_r[i] <= '0;
      for (int i = 0; i < 4; i++) eseq_r[i] <= '0;
      for (int i = 0; i < 2; i++) lts_r[i] <= '0;
    end else begin
      phase_r   <= phase_nxt;
      fill_r    <= fill_nxt;
      skipped_r <= skipped_nxt;
      skip_r    <= skip_nxt;
      flen_r    <= flen_nxt;
      bpos_r    <= bpos_nxt;
      pphase_r  <= pphase_nxt;
      window_r  <= window_nxt;
      eseq_r    <= eseq_nxt;
      lts_r     <= lts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

endmodule

/* rtl/scd_outq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_outq
// Result queue: takes up to ten results per cycle, hands out one per request.
// ----------------------------------------------------------------------------
module scd_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [3:0]          push_n,
  input  scd_pkg::res_t       push_d [scd_pkg::MAX_RESULTS],
  input  logic                pop,
  output logic                not_empty,
  output logic                nearly_full,
  output scd_pkg::res_t       head
);

  localparam int unsigned AW = $clog2(scd_pkg::OQ_DEPTH);

  scd_pkg::res_t  mem_r [scd_pkg::OQ_DEPTH];
  logic [AW-1:0]  wptr_r, wptr_nxt;
  logic [AW-1:0]  rptr_r, rptr_nxt;
  logic [AW:0]    count_r, count_nxt;

  assign not_empty   = (count_r != '0);
  assign nearly_full = (count_r > (AW+1)'(scd_pkg::OQ_DEPTH - scd_pkg::MAX_RESULTS));
  assign head        = mem_r[rptr_r];

  assign wptr_nxt  = wptr_r + AW'(push_n);
  assign rptr_nxt  = rptr_r + AW'(pop);
  assign count_nxt = count_r + (AW+1)'(push_n) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < scd_pkg::OQ_DEPTH; i++) begin
      logic [AW-1:0] off;
      off = AW'(i) - wptr_r;
      if ({1'b0, off} < (AW+1)'(push_n)) mem_r[i] <= push_d[off];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

/* rtl/stream_chunk_deframer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_chunk_deframer_unit
// Rebuilds data packets from a received chunk byte stream.
//
// Input channel (in_valid/in_stall/in_byte) takes one received byte per
// request. Result channel (out_*) gives one packet byte or status report per
// request. Each byte is processed in the cycle it is taken; its results enter
// a 16-entry result queue and appear on out_* once earlier results are taken.
// Throughput: one byte per cycle while in_stall is low. A frame header
// completion produces a burst of ten results; in_stall rises while the queue
// has fewer than ten free entries, so a whole burst always fits.
// Keepalive period lies at APB address 0 (reset 43); write only while idle.
// Reset (rst_n low, synchronous) empties the queue, clears sequence and
// timestamp tracking and starts a fresh preamble. A stalled receiver holds
// the head result; bytes keep being taken until the queue is nearly full.
// ----------------------------------------------------------------------------
module stream_chunk_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_stream_number,
  output logic [2:0]  out_status,
  output logic        out_keepalive_request,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]     period_r;
  logic           step;
  logic [3:0]     res_n;
  scd_pkg::res_t  res [scd_pkg::MAX_RESULTS];
  scd_pkg::res_t  head;
  logic           nearly_full;

  assign pready = 1'b1;
  assign prdata = (paddr == scd_pkg::REG_PERIOD) ? {24'd0, period_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= scd_pkg::PERIOD_RST;
    end else if (psel && penable && pwrite && paddr[2] == scd_pkg::REG_PERIOD[2]) begin
      period_r <= pwdata[7:0];
    end
  end

  assign in_stall = nearly_full;
  assign step     = in_valid && !nearly_full;

  scd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_byte (in_byte),
    .period  (period_r),
    .res_n   (res_n),
    .res     (res)
  );

  scd_outq u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_n      (res_n),
    .push_d      (res),
    .pop         (out_valid && !out_stall),
    .not_empty   (out_valid),
    .nearly_full (nearly_full),
    .head        (head)
  );

  assign out_byte              = head.data;
  assign out_last              = head.last;
  assign out_stream_number     = head.stream;
  assign out_status            = head.status;
  assign out_keepalive_request = head.ka;

endmodule

/* rtl/scd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module scd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       out_stream_number,
  input logic [2:0] out_status
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_status))
    else $error("stalled result changed");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty queue");

  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != scd_pkg::ST_DATA |->
      out_last && out_byte == 8'd0 && !out_stream_number)
    else $error("malformed error result");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= scd_pkg::ST_SHORT)
    else $error("status code out of range");

endmodule

bind stream_chunk_deframer_unit scd_checker u_scd_checker (.*);
